// ----- src/kchd_pkg.sv -----
`default_nettype none

package kchd_pkg;

    // Width of the key level and pulse fields.
    localparam int unsigned KEY_FIELD_W = 8;

    // Width of one press counter and of each threshold register.
    localparam int unsigned CNT_W = 8;

    // Default number of keys that carry a counter.
    localparam int unsigned NUM_KEYS_DEF = 8;

    // Configuration port widths.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD  = 8'd1;

    // Threshold reset values.
    localparam logic [CNT_W-1:0] CLICK_THRESHOLD_RST = 8'd3;
    localparam logic [CNT_W-1:0] HOLD_THRESHOLD_RST  = 8'd50;

    // Saturated counter value.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Thresholds shared by all key cells.
    typedef struct packed {
        logic [CNT_W-1:0] click_threshold;
        logic [CNT_W-1:0] hold_threshold;
    } thresholds_t;

endpackage

`default_nettype wire

// ----- src/kchd_cfg_regs.sv -----
`default_nettype none

module kchd_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kchd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [kchd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output kchd_pkg::thresholds_t                  thresholds
);

    logic [kchd_pkg::CNT_W-1:0] click_threshold_reg;
    logic [kchd_pkg::CNT_W-1:0] hold_threshold_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Threshold registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_threshold_reg <= kchd_pkg::CLICK_THRESHOLD_RST;
            hold_threshold_reg  <= kchd_pkg::HOLD_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kchd_pkg::REG_CLICK_THRESHOLD:
                begin
                    click_threshold_reg <= cfg_data[kchd_pkg::CNT_W-1:0];
                end
                kchd_pkg::REG_HOLD_THRESHOLD:
                begin
                    hold_threshold_reg <= cfg_data[kchd_pkg::CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign thresholds.click_threshold = click_threshold_reg;
    assign thresholds.hold_threshold  = hold_threshold_reg;

endmodule

`default_nettype wire

// ----- src/kchd_key_cell.sv -----
`default_nettype none

module kchd_key_cell
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  level,
    input  wire logic                  tick,
    input  wire kchd_pkg::thresholds_t thresholds,
    output logic                       click,
    output logic                       hold
);

    logic                        prev_level_reg;
    logic [kchd_pkg::CNT_W-1:0]  cnt_reg;
    logic [kchd_pkg::CNT_W-1:0]  cnt_next;
    logic [kchd_pkg::CNT_W-1:0]  cnt_adv;
    logic [kchd_pkg::CNT_W-1:0]  hold_th;
    logic [kchd_pkg::CNT_W-1:0]  park_value;

    assign hold_th = thresholds.hold_threshold;

    // The counter advances first; the edge rules then act on the advanced value.
    assign cnt_adv = (tick && (cnt_reg < hold_th)) ? cnt_reg + 1'b1 : cnt_reg;

    // A hold parks one above the threshold, saturating at the counter's top.
    assign park_value = (hold_th == kchd_pkg::CNT_MAX) ? kchd_pkg::CNT_MAX : hold_th + 1'b1;

    // Edge rules for press, steady hold and release.
    always_comb
    begin
        cnt_next = cnt_adv;
        click    = 1'b0;
        hold     = 1'b0;
        if (!prev_level_reg && level)
        begin
            cnt_next = '0;
        end
        else if (prev_level_reg && level)
        begin
            if (cnt_adv == hold_th)
            begin
                hold     = 1'b1;
                cnt_next = park_value;
            end
        end
        else if (prev_level_reg && !level)
        begin
            click    = (cnt_adv >= thresholds.click_threshold) && (cnt_adv < hold_th);
            cnt_next = '0;
        end
    end

    // Per-key state advances once per processed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (step)
        begin
            prev_level_reg <= level;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/key_click_hold_detector.sv -----
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_stall    raw_keys, count_tick
// out       out_valid / out_stall  click_pulses, hold_pulses
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat goes from the input register through the key cells to the result register;
// its result is held there while out_stall is high and leaves once out_stall is low.
// A new beat is accepted every cycle while the result side does not stall.
// All key cells work side by side, so the number of keys does not change the rate.
// Reset clears the key levels, the press counters and both handshake stages.
// When out_stall holds a result and a beat waits in the input register, in_stall rises.

module key_click_hold_detector
#(
    parameter int unsigned NUM_KEYS = kchd_pkg::NUM_KEYS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [kchd_pkg::KEY_FIELD_W-1:0]      raw_keys,
    input  wire logic                                  count_tick,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [kchd_pkg::KEY_FIELD_W-1:0]           click_pulses,
    output logic [kchd_pkg::KEY_FIELD_W-1:0]           hold_pulses,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [kchd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [kchd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    kchd_pkg::thresholds_t                    thresholds;

    logic                                     s1_valid_reg;
    logic [kchd_pkg::KEY_FIELD_W-1:0]         keys_reg;
    logic                                     tick_reg;
    logic                                     out_valid_reg;
    logic [kchd_pkg::KEY_FIELD_W-1:0]         click_reg;
    logic [kchd_pkg::KEY_FIELD_W-1:0]         hold_reg;
    logic                                     out_free;
    logic                                     s1_move;
    logic                                     in_take;
    logic [NUM_KEYS-1:0]                      cell_level;
    logic [NUM_KEYS-1:0]                      cell_click;
    logic [NUM_KEYS-1:0]                      cell_hold;
    logic [kchd_pkg::KEY_FIELD_W-1:0]         click_field;
    logic [kchd_pkg::KEY_FIELD_W-1:0]         hold_field;

    // Threshold registers.
    kchd_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .thresholds (thresholds)
    );

    // Pipeline flow control.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            keys_reg <= raw_keys;
            tick_reg <= count_tick;
        end
    end

    // One cell per key; keys past the field width always read as released.
    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_cell
            if (k < kchd_pkg::KEY_FIELD_W)
            begin : g_seen
                assign cell_level[k] = keys_reg[k];
            end
            else
            begin : g_unseen
                assign cell_level[k] = 1'b0;
            end

            kchd_key_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (s1_move),
                .level      (cell_level[k]),
                .tick       (tick_reg),
                .thresholds (thresholds),
                .click      (cell_click[k]),
                .hold       (cell_hold[k])
            );
        end

        // Only the first keys fit in the result fields.
        for (k = 0; k < kchd_pkg::KEY_FIELD_W; k++)
        begin : g_field
            if (k < NUM_KEYS)
            begin : g_used
                assign click_field[k] = cell_click[k];
                assign hold_field[k]  = cell_hold[k];
            end
            else
            begin : g_pad
                assign click_field[k] = 1'b0;
                assign hold_field[k]  = 1'b0;
            end
        end
    endgenerate

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            click_reg <= click_field;
            hold_reg  <= hold_field;
        end
    end

    assign out_valid    = out_valid_reg;
    assign click_pulses = click_reg;
    assign hold_pulses  = hold_reg;

    // A key never reports click and hold in the same result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((click_pulses & hold_pulses) == '0))
        else $error("click and hold fired together for one key");

    // A beat that moves on always shows up as a valid result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid)
        else $error("processed beat did not reach the result register");

    // Back-pressure only appears while the result register is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s1_valid_reg))
        else $error("input stalled without a held result");

    // A held result leaves the input beat in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && out_stall) |=> s1_valid_reg)
        else $error("input beat lost while result was held");

endmodule

`default_nettype wire
